@@ sv/tedt_pkg.sv @@
`default_nettype none
package tedt_pkg;
    localparam int MaxEdges   = 4096;
    localparam int MaxFaces   = 2048;
    localparam int VertexBits = 16;
    localparam int EdgeBits   = $clog2(MaxEdges);
    localparam int FaceBits   = $clog2(MaxFaces);

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StRange    = 3'd1;
    localparam logic [2:0] StThird    = 3'd2;
    localparam logic [2:0] StEdgeFull = 3'd3;
    localparam logic [2:0] StFaceFull = 3'd4;

    typedef struct packed {
        logic [VertexBits-1:0] lo;
        logic [VertexBits-1:0] hi;
    } t_pair;

    // request from the sequencer to the edge search engine
    typedef struct packed {
        logic  start;
        t_pair key;
    } t_srch_req;

    typedef struct packed {
        logic                done;
        logic                found;
        logic [EdgeBits-1:0] id;
        logic [1:0]          nfaces;
    } t_srch_rsp;
endpackage
`default_nettype wire

@@ sv/tedt_search.sv @@
`default_nettype none
// Linear scan of the edge table, one entry per cycle through a registered
// read port. The table is written by the commit sweep of the sequencer.
module tedt_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tedt_pkg::t_srch_req           i_req,
    input  wire logic [tedt_pkg::EdgeBits:0]   i_used,
    input  wire logic                          i_wr_en,
    input  wire logic [tedt_pkg::EdgeBits-1:0] i_wr_addr,
    input  wire tedt_pkg::t_pair               i_wr_pair,
    input  wire logic [1:0]                    i_wr_nf,
    output tedt_pkg::t_srch_rsp                o_rsp
);
    logic [2*tedt_pkg::VertexBits+1:0] mem [tedt_pkg::MaxEdges];
    logic [2*tedt_pkg::VertexBits+1:0] r_rd;
    logic [tedt_pkg::EdgeBits:0]       r_addr, r_cmp_addr;
    logic                              r_busy, r_cmp_vld;
    tedt_pkg::t_pair                   r_key;
    tedt_pkg::t_srch_rsp               r_rsp;
    logic                              hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_pair, i_wr_nf};
        end
        r_rd <= mem[r_addr[tedt_pkg::EdgeBits-1:0]];
    end

    assign hit = r_cmp_vld && (r_rd[2*tedt_pkg::VertexBits+1:2] == r_key);

    // done pulses for one cycle; found, id and nfaces hold until the next search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_rsp <= '0;
            r_addr <= '0;
            r_cmp_addr <= '0;
        end else begin
            if (i_req.start) begin
                r_key <= i_req.key;
                r_addr <= '0;
                r_busy <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_rsp.done <= 1'b0;
            end else if (r_busy) begin
                if (hit) begin
                    r_busy <= 1'b0;
                    r_cmp_vld <= 1'b0;
                    r_rsp <= '{done: 1'b1, found: 1'b1,
                               id: r_cmp_addr[tedt_pkg::EdgeBits-1:0],
                               nfaces: r_rd[1:0]};
                end else if (r_addr >= i_used) begin
                    // last used entry compared without a hit
                    r_busy <= 1'b0;
                    r_cmp_vld <= 1'b0;
                    r_rsp <= '{done: 1'b1, found: 1'b0, id: '0, nfaces: 2'd0};
                end else begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_addr <= r_addr;
                    r_addr <= r_addr + 1'b1;
                end
            end else begin
                r_rsp.done <= 1'b0;
            end
        end
    end
    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

@@ sv/triangle_edge_dedup_table.sv @@
// Timing: each side of an accepted triangle costs a linear scan of the edge
//   table, below edges_used, by a single search engine. Corner or face-count
//   rejects skip the searches and go straight to the result.
// Throughput: one triangle at a time; the next transfer comes no earlier than
//   the cycle after the result transfer.
// Reset: synchronous active low; clears counts, vertex_count and control. The
//   edge table itself is not cleared; only entries below edges_used are compared.
`default_nettype none
module triangle_edge_dedup_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // vertex_a, vertex_b, vertex_c
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // face_number, side_edge_0..2,
                                             // fresh_flags, status, zero pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data      // vertex_count
);
    localparam int EB = tedt_pkg::EdgeBits;
    localparam int VB = tedt_pkg::VertexBits;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_SIDE  = 7'b0010000,
        S_COMMIT= 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [16:0]          r_vcount;
    logic [EB:0]          r_edges;
    logic [tedt_pkg::FaceBits:0] r_faces;
    logic [VB-1:0]        r_v [3];
    logic [1:0]           r_side, r_nnew, r_ci;
    tedt_pkg::t_pair      r_new [3];
    tedt_pkg::t_pair      r_pair [3];   // ordered corner pair of each side
    logic [EB-1:0]        r_id [3];
    logic [1:0]           r_nf [3];     // face count of each side's edge after that side
    logic [2:0]           r_fresh, r_stat;
    tedt_pkg::t_srch_req  req;
    tedt_pkg::t_srch_rsp  rsp;
    tedt_pkg::t_pair      key;
    logic [VB-1:0]        p, q;
    logic                 wr_en;
    logic [EB-1:0]        wr_addr;
    tedt_pkg::t_pair      wr_pair;
    logic [1:0]           wr_nf;
    logic [EB-1:0]        cid;
    logic [1:0]           cnt, prior;
    logic                 pfound;
    logic [1:0]           pidx;

    always_comb begin
        p = r_v[r_side];
        q = (r_side == 2'd2) ? r_v[0] : r_v[r_side + 2'd1];
        key.lo = (p < q) ? p : q;
        key.hi = (p < q) ? q : p;
    end
    // one search per side, launched from S_LOOK
    assign req = '{start: (r_state == S_LOOK), key: key};

    // pending new edges of this face
    always_comb begin
        pfound = 1'b0;
        pidx = '0;
        for (int k = 0; k < 3; k++) begin
            if (!pfound && k < r_nnew && r_new[k] == key) begin
                pfound = 1'b1;
                pidx = 2'(k);
            end
        end
    end

    always_comb begin
        cid = rsp.found ? rsp.id : (pfound ? r_edges[EB-1:0] + EB'(pidx)
                                           : r_edges[EB-1:0] + EB'(r_nnew));
        prior = '0;
        for (int k = 0; k < 2; k++) begin
            if (k < r_side && r_id[k] == cid) prior = prior + 2'd1;
        end
        cnt = (rsp.found ? rsp.nfaces : 2'd0) + prior;
    end

    // commit: one side per cycle writes its edge with the count after that
    // side; a later side on the same edge overwrites with the higher count
    always_comb begin
        wr_en = (r_state == S_COMMIT);
        wr_addr = r_id[r_ci];
        wr_pair = r_pair[r_ci];
        wr_nf = r_nf[r_ci];
    end

    tedt_search u_search (
        .i_clk, .i_rst_n, .i_req(req), .i_used(r_edges),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_pair(wr_pair),
        .i_wr_nf(wr_nf), .o_rsp(rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_vcount <= '0; r_edges <= '0; r_faces <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_vcount <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_v[0] <= s_axis_tdata[15:0];
                    r_v[1] <= s_axis_tdata[31:16];
                    r_v[2] <= s_axis_tdata[47:32];
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_side <= '0; r_nnew <= '0; r_fresh <= '0; r_ci <= '0;
                    if (17'(r_v[0]) >= r_vcount || 17'(r_v[1]) >= r_vcount
                        || 17'(r_v[2]) >= r_vcount) begin
                        r_stat <= tedt_pkg::StRange; r_state <= S_OUT;
                    end else if (r_faces >= (tedt_pkg::FaceBits+1)'(tedt_pkg::MaxFaces)) begin
                        r_stat <= tedt_pkg::StFaceFull; r_state <= S_OUT;
                    end else begin
                        r_stat <= tedt_pkg::StOk; r_state <= S_LOOK;
                    end
                end
                S_LOOK: r_state <= S_WAIT;
                S_WAIT: if (rsp.done) r_state <= S_SIDE;
                S_SIDE: begin
                    if (!rsp.found && !pfound &&
                        (r_edges + (EB+1)'(r_nnew) >= (EB+1)'(tedt_pkg::MaxEdges))) begin
                        r_stat <= tedt_pkg::StEdgeFull; r_state <= S_OUT;
                    end else if (cnt >= 2'd2) begin
                        r_stat <= tedt_pkg::StThird; r_state <= S_OUT;
                    end else begin
                        r_id[r_side] <= cid;
                        r_pair[r_side] <= key;
                        r_nf[r_side] <= cnt + 2'd1;
                        if (!rsp.found && !pfound) begin
                            r_new[r_nnew] <= key;
                            r_nnew <= r_nnew + 2'd1;
                            r_fresh[r_side] <= 1'b1;
                        end
                        if (r_side == 2'd2) r_state <= S_COMMIT;
                        else begin
                            r_side <= r_side + 2'd1; r_state <= S_LOOK;
                        end
                    end
                end
                S_COMMIT: begin
                    r_ci <= r_ci + 2'd1;
                    if (r_ci == 2'd2) begin
                        r_edges <= r_edges + (EB+1)'(r_nnew);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!m_axis_tvalid) begin
                    m_axis_tvalid <= 1'b1;
                    if (r_stat == tedt_pkg::StOk) begin
                        m_axis_tdata <= {3'b000, r_stat, r_fresh,
                                         r_id[2], r_id[1], r_id[0], r_faces[10:0]};
                        r_faces <= r_faces + 1'b1;
                    end else begin
                        // rejected: edge ids and fresh flags read as zero
                        m_axis_tdata <= {3'b000, r_stat, 3'b000, 36'd0, r_faces[10:0]};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges <= (EB+1)'(tedt_pkg::MaxEdges)) else $error("edge count overflow");
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Faces and edges used by one run stay far below the tables.
    localparam int StallHold   = 400;
    localparam int WatchLimit  = 60000;   // > longest face at a full edge table plus longest stall

    typedef struct packed {
        logic [10:0] face;
        logic [11:0] e0, e1, e2;
        logic [2:0]  fresh;
        logic [2:0]  st;
    } t_face_res;

    // ---------------------------------------------------------------------
    // Scoreboard: mirror of the edge table and FIFO of expected face results
    // ---------------------------------------------------------------------
    class face_scoreboard;
        int unsigned vcount;
        int unsigned edges_used, faces_used;
        logic [15:0] lo_of[$], hi_of[$];
        int unsigned nfaces_of[$];
        t_face_res   pending[$];
        int          errors;

        function void reset_state();
            vcount = 0; edges_used = 0; faces_used = 0;
            lo_of.delete(); hi_of.delete(); nfaces_of.delete();
            pending.delete();
        endfunction

        function void expect_res(t_face_res r);
            pending.insert(pending.size(), r);
        endfunction

        function t_face_res reject(logic [2:0] st);
            t_face_res r;
            r = '0;
            r.face = faces_used[10:0];
            r.st = st;
            return r;
        endfunction

        // work out the result of one accepted triangle and commit its state
        function void note_triangle(logic [15:0] a, logic [15:0] b, logic [15:0] c);
            logic [15:0] v[3];
            logic [15:0] plo[3], phi[3];
            int unsigned ids[3], nnew, cnt, id;
            logic [2:0] fresh;
            logic [15:0] p, q, lo, hi;
            bit hit;
            t_face_res r;
            v[0] = a; v[1] = b; v[2] = c;
            nnew = 0; fresh = '0;
            for (int i = 0; i < 3; i++) begin
                if (v[i] >= vcount) begin
                    expect_res(reject(tedt_pkg::StRange));
                    return;
                end
            end
            if (faces_used >= tedt_pkg::MaxFaces) begin
                expect_res(reject(tedt_pkg::StFaceFull));
                return;
            end
            for (int i = 0; i < 3; i++) begin
                p = v[i]; q = v[(i+1)%3];
                lo = (p < q) ? p : q; hi = (p < q) ? q : p;
                hit = 0; cnt = 0; id = 0;
                for (int e = 0; e < edges_used; e++) begin
                    if (lo_of[e] == lo && hi_of[e] == hi) begin
                        hit = 1; id = e; cnt = nfaces_of[e];
                        break;
                    end
                end
                if (!hit) begin
                    for (int e = 0; e < nnew; e++) begin
                        if (plo[e] == lo && phi[e] == hi) begin
                            hit = 1; id = edges_used + e;
                            break;
                        end
                    end
                end
                if (!hit) begin
                    if (edges_used + nnew >= tedt_pkg::MaxEdges) begin
                        expect_res(reject(tedt_pkg::StEdgeFull));
                        return;
                    end
                    plo[nnew] = lo; phi[nnew] = hi;
                    id = edges_used + nnew;
                    nnew++;
                    fresh[i] = 1'b1;
                end
                for (int j = 0; j < i; j++)
                    if (ids[j] == id) cnt++;
                if (cnt >= 2) begin
                    expect_res(reject(tedt_pkg::StThird));
                    return;
                end
                ids[i] = id;
            end
            for (int i = 0; i < nnew; i++) begin
                lo_of.insert(lo_of.size(), plo[i]);
                hi_of.insert(hi_of.size(), phi[i]);
                nfaces_of.insert(nfaces_of.size(), 0);
            end
            edges_used += nnew;
            for (int i = 0; i < 3; i++)
                if (nfaces_of[ids[i]] < 2) nfaces_of[ids[i]]++;
            r.face = faces_used[10:0];
            r.e0 = ids[0][11:0]; r.e1 = ids[1][11:0]; r.e2 = ids[2][11:0];
            r.fresh = fresh; r.st = tedt_pkg::StOk;
            expect_res(r);
            faces_used++;
        endfunction

        task automatic report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task automatic check_result(logic [55:0] data);
            t_face_res g, w;
            g.face = data[10:0];  g.e0 = data[22:11]; g.e1 = data[34:23];
            g.e2 = data[46:35];   g.fresh = data[49:47]; g.st = data[52:50];
            if (pending.size() == 0) begin
                report("unexpected result", data[31:0], 0);
                return;
            end
            w = pending.pop_front();
            if (g.face  !== w.face)  report("face_number", g.face, w.face);
            if (g.e0    !== w.e0)    report("side_edge_0", g.e0, w.e0);
            if (g.e1    !== w.e1)    report("side_edge_1", g.e1, w.e1);
            if (g.e2    !== w.e2)    report("side_edge_2", g.e2, w.e2);
            if (g.fresh !== w.fresh) report("fresh_flags", g.fresh, w.fresh);
            if (g.st    !== w.st)    report("status", g.st, w.st);
            if (data[55:53] !== 3'b0) report("pad", data[55:53], 0);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // vertex_a, vertex_b, vertex_c
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // face_number, side_edge_0..2, fresh, status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;       // vertex_count

    face_scoreboard sb;
    bit hold_sink = 0;      // long receiver hold-off requested
    bit stalls_on = 1;
    int idle_cycles = 0;

    triangle_edge_dedup_table uut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    // receiver: own stall pattern, quiet stretches, plus a long hold-off
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_sink) m_axis_tready <= 1'b0;
            else if (!stalls_on || (phase % 97) > 60) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // burst/gap sender state
    int burst_left = 0;

    // offer one triangle; valid stays up within a burst, drops for a gap
    task automatic send_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_triangle(a, b, c);
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_vcount(int unsigned n);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n[16:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.vcount = n;
    endtask

    // random triangle over a vertex pool of the given size; small pools share edges often
    task automatic rand_tri(int unsigned pool);
        logic [15:0] a, b, c;
        int k;
        k = $urandom_range(0, 19);
        a = 16'($urandom_range(0, pool - 1));
        b = 16'($urandom_range(0, pool - 1));
        c = 16'($urandom_range(0, pool - 1));
        if (k == 0) a = 16'($urandom);            // wide index, mostly out of range
        else if (k == 1) c = b;                   // degenerate side
        send_tri(a, b, c);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value 0: every corner rejected
        send_tri(16'd0, 16'd0, 16'd0);
        write_vcount(17'd65536);
        // directed: extremes, shared edges, repeated side, third face
        send_tri(16'hFFFF, 16'h0000, 16'h5555);
        send_tri(16'h0000, 16'hFFFF, 16'hAAAA);   // reuses edge 0
        send_tri(16'hFFFF, 16'h0000, 16'h1234);   // third face on edge 0
        send_tri(16'd7, 16'd7, 16'd7);            // all sides degenerate, same edge
        send_tri(16'd1, 16'd2, 16'd1);            // side repeated within face
        send_tri(16'd2, 16'd1, 16'd3);
        write_vcount(17'd10);
        send_tri(16'd9, 16'd8, 16'd10);           // vertex out of range
        send_tri(16'd9, 16'd8, 16'd0);
        write_vcount(17'd1);
        send_tri(16'd0, 16'd0, 16'd0);            // degenerate: third use of its own edge
        write_vcount(17'd0);
        send_tri(16'd0, 16'd0, 16'd0);

        // random phases with several vertex counts
        write_vcount(17'd24);
        for (int i = 0; i < 150; i++) rand_tri(26);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_sink = 1;
                repeat (StallHold) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int i = 0; i < 10; i++) rand_tri(26);
        join
        stalls_on = 0;
        write_vcount(17'd300);
        for (int i = 0; i < 150; i++) rand_tri(300);
        stalls_on = 1;
        write_vcount(17'd6);
        for (int i = 0; i < 60; i++) rand_tri(7);
        write_vcount(17'd65535);
        for (int i = 0; i < 100; i++) rand_tri(($urandom_range(0, 1) == 0) ? 40 : 65535);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
